// ----- sv/priority_deque_with_cancel_assert.svh -----
// ---------------------------------------------------------------------------
// priority_deque_with_cancel_assert.svh
// Assertion macros for the request deque sequencer. Each macro expects
// signals named clk and rst in the module that uses it.
// ---------------------------------------------------------------------------
`ifndef PRIORITY_DEQUE_WITH_CANCEL_ASSERT_SVH
`define PRIORITY_DEQUE_WITH_CANCEL_ASSERT_SVH

// Check a condition at every clock edge outside reset
`define PDQ_ASSERT_HOLDS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Check a consequence in the same cycle as its trigger
`define PDQ_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequence in the cycle after its trigger
`define PDQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/pdq_pkg.sv -----
// ---------------------------------------------------------------------------
// pdq_pkg
// Types, codes and slot arithmetic for the request deque.
// ---------------------------------------------------------------------------
package pdq_pkg;

  // Number of record slots
  localparam int QUEUE_DEPTH = 16;
  localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam int KEY_W  = 32;
  localparam int CODE_W = 16;
  localparam int TIME_W = 11;
  localparam int ID_W   = 16;
  localparam int OP_W   = 3;
  localparam int STAT_W = 2;

  // Request kinds
  typedef enum logic [OP_W-1:0] {
    OP_ADD_BACK = 3'd0,
    OP_ADD_VIP  = 3'd1,
    OP_POP      = 3'd2,
    OP_SEARCH   = 3'd3,
    OP_CANCEL   = 3'd4,
    OP_REVERSE  = 3'd5
  } pdq_op_e;

  // Result status codes
  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } pdq_status_e;

  // One stored record
  typedef struct packed {
    logic              vip;
    logic [TIME_W-1:0] tod;
    logic [CODE_W-1:0] destination;
    logic [CODE_W-1:0] pickup;
    logic [KEY_W-1:0]  passenger;
    logic [ID_W-1:0]   id;
  } pdq_rec_t;

  // One incoming request
  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [KEY_W-1:0]  key;
    logic [CODE_W-1:0] pickup;
    logic [CODE_W-1:0] destination;
    logic [TIME_W-1:0] tod;
    logic [ID_W-1:0]   req_id;
  } pdq_cmd_t;

  // One result
  typedef struct packed {
    pdq_status_e status;
    pdq_rec_t    rec;
  } pdq_res_t;

  // Record store access for one cycle
  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    pdq_rec_t         wdata;
    logic [IDX_W-1:0] raddr;
  } pdq_mem_req_t;

  // Physical slot at offset off from base; the depth is taken off at most once
  function automatic logic [IDX_W-1:0] slot_of(logic [IDX_W-1:0] base,
                                               logic [CNT_W-1:0] off);
    logic [CNT_W:0] sum;
    sum = (CNT_W+1)'(base) + (CNT_W+1)'(off);
    if (sum >= (CNT_W+1)'(QUEUE_DEPTH)) begin
      sum = sum - (CNT_W+1)'(QUEUE_DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

endpackage

// ----- sv/pdq_store.sv -----
// ---------------------------------------------------------------------------
// pdq_store
// Record store: one write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module pdq_store (
  input  logic                  clk,
  input  pdq_pkg::pdq_mem_req_t mem_req,
  output pdq_pkg::pdq_rec_t     rd_data
);

  pdq_pkg::pdq_rec_t mem [pdq_pkg::QUEUE_DEPTH];

  // Write the addressed slot and register the read slot
  always_ff @(posedge clk) begin
    if (mem_req.we) begin
      mem[mem_req.waddr] <= mem_req.wdata;
    end
    rd_data <= mem[mem_req.raddr];
  end

endmodule

// ----- sv/pdq_seq.sv -----
// ---------------------------------------------------------------------------
// pdq_seq
// Request sequencer: keeps the deque pointers, walks the store with one
// shared comparator for search and cancel, and closes gaps after a cancel.
// ---------------------------------------------------------------------------
`include "priority_deque_with_cancel_assert.svh"

module pdq_seq (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  pdq_pkg::pdq_cmd_t     in_cmd,
  output pdq_pkg::pdq_mem_req_t mem_req,
  input  pdq_pkg::pdq_rec_t     rd_data,
  output logic                  res_valid,
  input  logic                  res_ready,
  output pdq_pkg::pdq_res_t     res
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_POP,
    S_SCAN,
    S_SHIFT,
    S_DONE
  } state_t;

  state_t                          state;
  logic [pdq_pkg::IDX_W-1:0]       front;
  logic [pdq_pkg::CNT_W-1:0]       count;
  logic                            rev;
  logic [pdq_pkg::ID_W-1:0]        next_id;
  logic [pdq_pkg::CNT_W-1:0]       issue_p;
  logic                            rd_live;
  logic [pdq_pkg::CNT_W-1:0]       rd_off;
  logic [pdq_pkg::OP_W-1:0]        op_r;
  logic [pdq_pkg::KEY_W-1:0]       key_r;
  logic [pdq_pkg::ID_W-1:0]        id_r;

  logic                            full;
  logic                            empty;
  logic                            add_op;
  logic                            add_low;
  logic [pdq_pkg::IDX_W-1:0]       front_dec;
  logic [pdq_pkg::ID_W-1:0]        id_inc;
  logic [pdq_pkg::CNT_W-1:0]       last_off;
  logic [pdq_pkg::CNT_W-1:0]       scan_off;
  logic                            scan_issue;
  logic                            shift_issue;
  logic [pdq_pkg::KEY_W-1:0]       cmp_a;
  logic [pdq_pkg::KEY_W-1:0]       cmp_b;
  logic                            hit;
  pdq_pkg::pdq_rec_t               add_rec;
  pdq_pkg::pdq_res_t               start_res;
  state_t                          start_state;

  assign in_ready  = (state == S_IDLE);
  assign res_valid = (state == S_DONE);

  // Occupancy and pointer helpers
  assign full      = (count == pdq_pkg::CNT_W'(pdq_pkg::QUEUE_DEPTH));
  assign empty     = (count == '0);
  assign add_op    = (in_cmd.op == pdq_pkg::OP_ADD_BACK) ||
                     (in_cmd.op == pdq_pkg::OP_ADD_VIP);
  assign add_low   = ((in_cmd.op == pdq_pkg::OP_ADD_BACK) && rev) ||
                     ((in_cmd.op == pdq_pkg::OP_ADD_VIP) && !rev);
  assign front_dec = (front == '0) ? pdq_pkg::IDX_W'(pdq_pkg::QUEUE_DEPTH - 1)
                                   : front - pdq_pkg::IDX_W'(1);
  assign id_inc    = next_id + pdq_pkg::ID_W'(1);
  assign last_off  = count - pdq_pkg::CNT_W'(1);
  assign scan_off  = rev ? (last_off - issue_p) : issue_p;

  assign scan_issue  = (state == S_SCAN) && (issue_p < count) && !hit;
  assign shift_issue = (state == S_SHIFT) && (issue_p < count);

  // Shared comparator: key for search, id for cancel
  assign cmp_a = (op_r == pdq_pkg::OP_CANCEL) ? pdq_pkg::KEY_W'(rd_data.id)
                                              : rd_data.passenger;
  assign cmp_b = (op_r == pdq_pkg::OP_CANCEL) ? pdq_pkg::KEY_W'(id_r) : key_r;
  assign hit   = (state == S_SCAN) && rd_live && (cmp_a == cmp_b);

  // Build the record for an add
  always_comb begin
    add_rec             = '0;
    add_rec.id          = id_inc;
    add_rec.passenger   = in_cmd.key;
    add_rec.pickup      = in_cmd.pickup;
    add_rec.destination = in_cmd.destination;
    add_rec.tod         = in_cmd.tod;
    add_rec.vip         = (in_cmd.op == pdq_pkg::OP_ADD_VIP);
  end

  // Pick the opening result and the next state for a new request
  always_comb begin
    start_res        = '0;
    start_res.status = pdq_pkg::ST_OK;
    start_state      = S_DONE;
    unique case (in_cmd.op)
      pdq_pkg::OP_ADD_BACK, pdq_pkg::OP_ADD_VIP: begin
        if (full) begin
          start_res.status = pdq_pkg::ST_FULL;
        end else begin
          start_res.rec.id = id_inc;
        end
      end
      pdq_pkg::OP_POP: begin
        if (empty) begin
          start_res.status = pdq_pkg::ST_EMPTY;
        end else begin
          start_state = S_POP;
        end
      end
      pdq_pkg::OP_SEARCH, pdq_pkg::OP_CANCEL: begin
        if (empty) begin
          start_res.status = pdq_pkg::ST_EMPTY;
        end else begin
          start_state = S_SCAN;
        end
      end
      default: begin
        // reverse and unused kinds answer at once
      end
    endcase
  end

  // Drive the store ports
  always_comb begin
    mem_req       = '0;
    mem_req.wdata = add_rec;
    unique case (state)
      S_IDLE: begin
        mem_req.we    = in_valid && add_op && !full;
        mem_req.waddr = add_low ? front_dec : pdq_pkg::slot_of(front, count);
        mem_req.raddr = pdq_pkg::slot_of(front, rev ? last_off : '0);
      end
      S_SCAN: begin
        mem_req.raddr = pdq_pkg::slot_of(front, scan_off);
      end
      S_SHIFT: begin
        mem_req.we    = rd_live;
        mem_req.waddr = pdq_pkg::slot_of(front, rd_off - pdq_pkg::CNT_W'(1));
        mem_req.wdata = rd_data;
        mem_req.raddr = pdq_pkg::slot_of(front, issue_p);
      end
      default: begin
        mem_req.raddr = front;
      end
    endcase
  end

  // Sequencer, pointers and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      front   <= '0;
      count   <= '0;
      rev     <= 1'b0;
      next_id <= '0;
      issue_p <= '0;
      rd_live <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            op_r    <= in_cmd.op;
            key_r   <= in_cmd.key;
            id_r    <= in_cmd.req_id;
            res     <= start_res;
            issue_p <= '0;
            rd_live <= 1'b0;
            state   <= start_state;
            // take a slot and a fresh id for an accepted add
            if (add_op && !full) begin
              next_id <= id_inc;
              count   <= count + pdq_pkg::CNT_W'(1);
              if (add_low) begin
                front <= front_dec;
              end
            end
            if (in_cmd.op == pdq_pkg::OP_REVERSE) begin
              rev <= !rev;
            end
          end
        end
        S_POP: begin
          // take the front record and drop it
          res.rec <= rd_data;
          if (!rev) begin
            front <= pdq_pkg::slot_of(front, pdq_pkg::CNT_W'(1));
          end
          count <= last_off;
          state <= S_DONE;
        end
        S_SCAN: begin
          if (hit) begin
            res.rec <= rd_data;
            rd_live <= 1'b0;
            if (op_r == pdq_pkg::OP_CANCEL) begin
              issue_p <= rd_off + pdq_pkg::CNT_W'(1);
              state   <= S_SHIFT;
            end else begin
              state <= S_DONE;
            end
          end else if (scan_issue) begin
            issue_p <= issue_p + pdq_pkg::CNT_W'(1);
            rd_off  <= scan_off;
            rd_live <= 1'b1;
          end else begin
            rd_live <= 1'b0;
            if (!rd_live) begin
              res.status <= pdq_pkg::ST_NOT_FOUND;
              state      <= S_DONE;
            end
          end
        end
        S_SHIFT: begin
          // move each later record one slot down toward the gap
          if (shift_issue) begin
            issue_p <= issue_p + pdq_pkg::CNT_W'(1);
            rd_off  <= issue_p;
            rd_live <= 1'b1;
          end else begin
            rd_live <= 1'b0;
            if (!rd_live) begin
              count <= last_off;
              state <= S_DONE;
            end
          end
        end
        S_DONE: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Checks
  `PDQ_ASSERT_HOLDS(a_count_bound, count <= pdq_pkg::CNT_W'(pdq_pkg::QUEUE_DEPTH),
                    "count above depth")
  `PDQ_ASSERT_IMPL(a_scan_no_write, state == S_SCAN, !mem_req.we, "store write during scan")
  `PDQ_ASSERT_IMPL(a_shift_ports, (state == S_SHIFT) && mem_req.we && shift_issue,
                   mem_req.waddr != mem_req.raddr, "shift reads the slot it writes")
  `PDQ_ASSERT_NEXT(a_full_holds, in_valid && in_ready && add_op && full,
                   (count == $past(count)) && (next_id == $past(next_id)),
                   "full add changed state")
  `PDQ_ASSERT_NEXT(a_id_stable, state != S_IDLE, $stable(next_id), "id counter moved while busy")

endmodule

// ----- sv/priority_deque_with_cancel.sv -----
// ---------------------------------------------------------------------------
// priority_deque_with_cancel
// Bounded deque of request records with VIP front adds, search and cancel.
// ---------------------------------------------------------------------------
// One request is worked on at a time; s_axis_tready is high only while the
// sequencer is idle. Add, reverse and unused kinds answer straight from the
// idle state, and pop reads the front record first. Search reads one record a
// cycle through the single read port of the record store, in logical order
// until a match, and compares it in one shared comparator. Cancel walks the
// same way and then moves every record stored past the removed one down by
// one slot, one per cycle on the same port. A finished result waits in the
// output register, so the next request is taken while it stalls; a later
// result then waits in the sequencer, which takes no new request until the
// output register frees.
// ---------------------------------------------------------------------------
module priority_deque_with_cancel (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // passenger_key[31:0], pickup_code[47:32], destination_code[63:48],
  // time_of_day[74:64], request_id[90:75], zero fill [95:91]
  input  logic [95:0] s_axis_tdata,
  // req_type[2:0]
  input  logic [2:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // out_id[15:0], out_passenger[47:16], out_pickup[63:48],
  // out_destination[79:64], out_time[90:80], out_vip[91], zero fill [95:92]
  output logic [95:0] m_axis_tdata,
  // op_status[1:0]
  output logic [1:0]  m_axis_tuser
);

  pdq_pkg::pdq_cmd_t     cmd;
  pdq_pkg::pdq_mem_req_t mem_req;
  pdq_pkg::pdq_rec_t     rd_data;
  pdq_pkg::pdq_res_t     res;
  pdq_pkg::pdq_res_t     out_res;
  logic                  res_valid;
  logic                  res_ready;

  // Unpack the request
  always_comb begin
    cmd.op          = pdq_pkg::pdq_op_e'(s_axis_tuser);
    cmd.key         = s_axis_tdata[31:0];
    cmd.pickup      = s_axis_tdata[47:32];
    cmd.destination = s_axis_tdata[63:48];
    cmd.tod         = s_axis_tdata[74:64];
    cmd.req_id      = s_axis_tdata[90:75];
  end

  pdq_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_cmd    (cmd),
    .mem_req   (mem_req),
    .rd_data   (rd_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  pdq_store u_store (
    .clk     (clk),
    .mem_req (mem_req),
    .rd_data (rd_data)
  );

  // Output register: load when empty or being drained
  assign res_ready = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else begin
      if (res_ready) begin
        m_axis_tvalid <= res_valid;
      end
      if (res_valid && res_ready) begin
        out_res <= res;
      end
    end
  end

  // Pack the result
  assign m_axis_tuser = out_res.status;
  assign m_axis_tdata = {4'b0, out_res.rec.vip, out_res.rec.tod, out_res.rec.destination,
                         out_res.rec.pickup, out_res.rec.passenger, out_res.rec.id};

endmodule

// ----- tb/tb.sv -----
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the request deque with cancel. A directed table
// covers the empty, full and not-found cases, every request kind and the
// extreme field values. The full queue is then drained to one record with
// the receiver always ready, and a random phase follows. Every result is
// checked field by field, typed rows against their pinned value, the rest
// against a behavioral copy of the deque, kept in logical order. The sender
// runs in bursts; the receiver stalls on a pattern, once for a long stretch.
// ---------------------------------------------------------------------------
module tb;

  // Request kinds that the block takes but does not act on
  localparam logic [pdq_pkg::OP_W-1:0] OP_SPARE_6 = 3'd6;
  localparam logic [pdq_pkg::OP_W-1:0] OP_SPARE_7 = 3'd7;
  localparam int RANDOM_REQUESTS = 700;
  localparam int HOLD_CYCLES     = 300;

  // One stimulus row; want is used only where typed is set
  typedef struct {
    pdq_pkg::pdq_cmd_t cmd;
    bit                typed;
    pdq_pkg::pdq_res_t want;
  } ride_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [95:0] s_axis_tdata = '0;
  logic [2:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [95:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  // Behavioral deque: records in logical order, front first
  pdq_pkg::pdq_rec_t        rides[$];
  logic [pdq_pkg::ID_W-1:0] ride_id_ctr = '0;
  pdq_pkg::pdq_res_t        results_due[$];
  int                       fail_count = 0;
  int                       burst_left = 0;
  bit                       rx_free = 1'b0;
  bit                       rx_hold_req = 1'b0;

  priority_deque_with_cancel dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Apply one request to the behavioral deque and return its result
  function automatic pdq_pkg::pdq_res_t apply_request(input pdq_pkg::pdq_cmd_t c);
    pdq_pkg::pdq_res_t res;
    pdq_pkg::pdq_rec_t rec;
    int                hit;
    res = '0;
    rec = '0;
    hit = -1;
    case (c.op)
      pdq_pkg::OP_ADD_BACK, pdq_pkg::OP_ADD_VIP: begin
        if (rides.size() >= pdq_pkg::QUEUE_DEPTH) begin
          res.status = pdq_pkg::ST_FULL;
        end else begin
          ride_id_ctr     = ride_id_ctr + pdq_pkg::ID_W'(1);
          rec.id          = ride_id_ctr;
          rec.passenger   = c.key;
          rec.pickup      = c.pickup;
          rec.destination = c.destination;
          rec.tod         = c.tod;
          rec.vip         = (c.op == pdq_pkg::OP_ADD_VIP);
          if (rec.vip) begin
            rides.push_front(rec);
          end else begin
            rides.push_back(rec);
          end
          res.rec.id = ride_id_ctr;
        end
      end
      pdq_pkg::OP_POP: begin
        if (rides.size() == 0) begin
          res.status = pdq_pkg::ST_EMPTY;
        end else begin
          res.rec = rides.pop_front();
        end
      end
      pdq_pkg::OP_SEARCH, pdq_pkg::OP_CANCEL: begin
        if (rides.size() == 0) begin
          res.status = pdq_pkg::ST_EMPTY;
        end else begin
          // first match in logical order
          for (int i = 0; i < rides.size() && hit < 0; i++) begin
            if ((c.op == pdq_pkg::OP_SEARCH) ? (rides[i].passenger == c.key)
                                             : (rides[i].id == c.req_id)) begin
              hit = i;
            end
          end
          if (hit < 0) begin
            res.status = pdq_pkg::ST_NOT_FOUND;
          end else begin
            res.rec = rides[hit];
            if (c.op == pdq_pkg::OP_CANCEL) begin
              rides.delete(hit);
            end
          end
        end
      end
      pdq_pkg::OP_REVERSE: begin
        for (int i = 0; i < rides.size() / 2; i++) begin
          rec = rides[i];
          rides[i] = rides[rides.size() - 1 - i];
          rides[rides.size() - 1 - i] = rec;
        end
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  function automatic ride_row_t job(input logic [pdq_pkg::OP_W-1:0] op,
                                    input logic [pdq_pkg::KEY_W-1:0] key,
                                    input logic [pdq_pkg::CODE_W-1:0] pickup,
                                    input logic [pdq_pkg::CODE_W-1:0] destination,
                                    input logic [pdq_pkg::TIME_W-1:0] tod,
                                    input logic [pdq_pkg::ID_W-1:0] rid);
    ride_row_t r;
    r.cmd.op          = pdq_pkg::pdq_op_e'(op);
    r.cmd.key         = key;
    r.cmd.pickup      = pickup;
    r.cmd.destination = destination;
    r.cmd.tod         = tod;
    r.cmd.req_id      = rid;
    r.typed           = 1'b0;
    r.want            = '0;
    return r;
  endfunction

  // Pin the expected status and id; every other result field is zero
  function automatic ride_row_t pin(input ride_row_t r, input pdq_pkg::pdq_status_e st,
                                    input logic [pdq_pkg::ID_W-1:0] id);
    r.typed       = 1'b1;
    r.want        = '0;
    r.want.status = st;
    r.want.rec.id = id;
    return r;
  endfunction

  // Draw a random request; lean 0 favors adds, 1 favors removals
  function automatic ride_row_t draw_job(input int lean);
    logic [pdq_pkg::OP_W-1:0]  op;
    logic [pdq_pkg::KEY_W-1:0] key;
    logic [pdq_pkg::ID_W-1:0]  rid;
    int                        add_pct;
    int                        pick;
    add_pct = (lean == 0) ? 60 : (lean == 1) ? 20 : 40;
    pick = $urandom_range(0, 99);
    if (pick < add_pct) begin
      op = $urandom_range(0, 1) ? pdq_pkg::OP_ADD_VIP : pdq_pkg::OP_ADD_BACK;
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        op = pdq_pkg::OP_POP;
      end else if (pick < 60) begin
        op = pdq_pkg::OP_SEARCH;
      end else if (pick < 85) begin
        op = pdq_pkg::OP_CANCEL;
      end else if (pick < 96) begin
        op = pdq_pkg::OP_REVERSE;
      end else if (pick < 98) begin
        op = OP_SPARE_6;
      end else begin
        op = OP_SPARE_7;
      end
    end
    // small key pool so that several records share a key
    key = ($urandom_range(0, 2) == 0) ? $urandom : {8{4'($urandom_range(0, 15))}};
    if (op == pdq_pkg::OP_SEARCH && rides.size() > 0 && $urandom_range(0, 3) != 0) begin
      key = rides[$urandom_range(0, rides.size() - 1)].passenger;
    end
    rid = 16'($urandom);
    if (op == pdq_pkg::OP_CANCEL && rides.size() > 0 && $urandom_range(0, 3) != 0) begin
      rid = rides[$urandom_range(0, rides.size() - 1)].id;
    end
    return job(op, key, 16'($urandom), 16'($urandom), 11'($urandom_range(0, 1439)), rid);
  endfunction

  task automatic report_mismatch(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    fail_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
    end
  endtask

  // Offer one request from a falling edge; record its result on acceptance
  task automatic send(input ride_row_t r);
    pdq_pkg::pdq_res_t predicted;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= r.cmd.op;
    s_axis_tdata  <= {5'd0, r.cmd.req_id, r.cmd.tod, r.cmd.destination,
                      r.cmd.pickup, r.cmd.key};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    predicted = apply_request(r.cmd);
    results_due.push_back(r.typed ? r.want : predicted);
    @(negedge clk);
  endtask

  // Insert a random gap once the current burst is used up
  task automatic pace();
    if (burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? 48 : $urandom_range(1, 12);
    end
    burst_left--;
  endtask

  // Check each accepted result against the oldest expectation
  always @(posedge clk) begin : result_check
    pdq_pkg::pdq_res_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (results_due.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending, status %0d", m_axis_tuser));
      end else begin
        want = results_due.pop_front();
        check_field("op_status", 32'(m_axis_tuser), 32'(want.status));
        check_field("out_id", 32'(m_axis_tdata[15:0]), 32'(want.rec.id));
        check_field("out_passenger", m_axis_tdata[47:16], want.rec.passenger);
        check_field("out_pickup", 32'(m_axis_tdata[63:48]), 32'(want.rec.pickup));
        check_field("out_destination", 32'(m_axis_tdata[79:64]), 32'(want.rec.destination));
        check_field("out_time", 32'(m_axis_tdata[90:80]), 32'(want.rec.tod));
        check_field("out_vip", 32'(m_axis_tdata[91]), 32'(want.rec.vip));
      end
    end
  end

  // Receiver: stall on a random pattern, with free-running stretches and one long hold
  initial begin : receiver
    int          phase;
    int          hold_left;
    logic [31:0] pattern;
    phase = 0;
    hold_left = 0;
    pattern = '1;
    forever begin
      @(negedge clk);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (phase == 0) begin
        pattern = ($urandom_range(0, 3) == 0) ? '1 : ($urandom | $urandom);
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= rx_free | pattern[phase];
      end
      phase = (phase + 1) % 32;
    end
  end

  // Hard stop for a hung run
  initial begin
    #50_000_000;
    $display("tb failed");
    $finish;
  end

  initial begin : stimulus
    ride_row_t table_rows[$];
    int        lean;

    // extremes, empty and not-found cases, spare kinds
    table_rows.push_back(pin(job(pdq_pkg::OP_POP, 0, 0, 0, 0, 0), pdq_pkg::ST_EMPTY, 0));
    table_rows.push_back(pin(job(pdq_pkg::OP_SEARCH, 0, 0, 0, 0, 0), pdq_pkg::ST_EMPTY, 0));
    table_rows.push_back(pin(job(pdq_pkg::OP_CANCEL, 0, 0, 0, 0, 0), pdq_pkg::ST_EMPTY, 0));
    table_rows.push_back(pin(job(pdq_pkg::OP_REVERSE, 0, 0, 0, 0, 0), pdq_pkg::ST_OK, 0));
    table_rows.push_back(pin(job(OP_SPARE_6, '1, '1, '1, '1, '1), pdq_pkg::ST_OK, 0));
    table_rows.push_back(pin(job(OP_SPARE_7, 0, 0, 0, 0, 0), pdq_pkg::ST_OK, 0));
    table_rows.push_back(pin(job(pdq_pkg::OP_ADD_BACK, '1, '1, '1, 11'd1439, '1),
                             pdq_pkg::ST_OK, 16'd1));
    table_rows.push_back(pin(job(pdq_pkg::OP_ADD_VIP, 0, 0, 0, 0, 0), pdq_pkg::ST_OK, 16'd2));
    table_rows.push_back(pin(job(pdq_pkg::OP_ADD_BACK, 32'h5555_5555, 16'hAAAA, 16'h5555,
                                 11'd512, 16'h5555), pdq_pkg::ST_OK, 16'd3));
    table_rows.push_back(job(pdq_pkg::OP_SEARCH, '1, 0, 0, 0, 0));
    table_rows.push_back(pin(job(pdq_pkg::OP_SEARCH, 32'h0000_0001, 0, 0, 0, 0),
                             pdq_pkg::ST_NOT_FOUND, 0));
    table_rows.push_back(pin(job(pdq_pkg::OP_CANCEL, 0, 0, 0, 0, '1),
                             pdq_pkg::ST_NOT_FOUND, 0));
    table_rows.push_back(pin(job(pdq_pkg::OP_REVERSE, 0, 0, 0, 0, 0), pdq_pkg::ST_OK, 0));
    table_rows.push_back(job(pdq_pkg::OP_CANCEL, 0, 0, 0, 0, 16'd2));
    table_rows.push_back(job(pdq_pkg::OP_POP, 0, 0, 0, 0, 0));
    // fill to capacity, then two rejected adds
    for (int k = 0; k < pdq_pkg::QUEUE_DEPTH - 1; k++) begin
      table_rows.push_back(pin(job((k % 2) ? pdq_pkg::OP_ADD_VIP : pdq_pkg::OP_ADD_BACK,
                                   $urandom, 16'($urandom), 16'($urandom),
                                   11'($urandom_range(0, 1439)), 0),
                               pdq_pkg::ST_OK, 16'(k + 4)));
    end
    table_rows.push_back(pin(job(pdq_pkg::OP_ADD_BACK, '1, '1, '1, '1, 0),
                             pdq_pkg::ST_FULL, 0));
    table_rows.push_back(pin(job(pdq_pkg::OP_ADD_VIP, 0, 0, 0, 0, 0), pdq_pkg::ST_FULL, 0));

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (table_rows[i]) begin
      pace();
      send(table_rows[i]);
    end

    // drain to one record with the receiver always ready
    rx_free = 1'b1;
    while (rides.size() > 1) send(job(pdq_pkg::OP_POP, 0, 0, 0, 0, 0));
    rx_free = 1'b0;

    lean = 0;
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      if (n % 50 == 0) begin
        lean = $urandom_range(0, 2);
      end
      // hold the output side while requests keep coming
      if (n == RANDOM_REQUESTS / 2) begin
        rx_hold_req = 1'b1;
      end
      pace();
      send(draw_job(lean));
    end
    s_axis_tvalid <= 1'b0;

    while (results_due.size() != 0) @(negedge clk);
    repeat (3 * pdq_pkg::QUEUE_DEPTH) @(negedge clk);
    if (fail_count == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
